[hw/rtl/epc_pkg.sv]
`timescale 1ns / 1ps

package epc_pkg;

    // Pipeline depth from input register to output register
    localparam int unsigned PIPE_DEPTH = 8;

    // Seconds to days: (secs >> 7) / 675 by reciprocal multiply
    localparam logic [25:0] DAY_RECIP      = 26'd50903317;
    localparam int unsigned DAY_SHIFT      = 35;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;

    // Seconds of day to hour: (rem >> 4) / 225
    localparam logic [13:0] HOUR_RECIP     = 14'd9321;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;

    // Seconds of hour to minute: (rem >> 2) / 15
    localparam logic [10:0] MIN_RECIP      = 11'd1093;
    localparam logic [11:0] SECS_PER_MIN   = 12'd60;

    // Day count is rebased to 1968-01-01, the start of a four-year cycle
    localparam logic [15:0] DAYS_1968_1970 = 16'd731;
    // 2100-03-01 counted from 1968-01-01; from it on, insert the missing Feb 29
    localparam logic [15:0] DAY_2100_MAR1  = 16'd48272;
    localparam logic [16:0] CYCLE_RECIP    = 17'd91868;
    localparam int unsigned CYCLE_SHIFT    = 27;
    localparam logic [15:0] DAYS_PER_CYCLE = 16'd1461;
    localparam logic [11:0] CYCLE_BASE_YEAR = 12'd1968;

    localparam logic [10:0] CYC_Y1_START = 11'd366;
    localparam logic [10:0] CYC_Y2_START = 11'd731;
    localparam logic [10:0] CYC_Y3_START = 11'd1096;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [3:0] MONTH_FEB = 4'd1;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    // First day of year of a month, with the leap day counted from March on
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        base = (m < 4'd12) ? MONTH_START[m] : 9'd0;
        if (leap && (m > MONTH_FEB)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

[hw/rtl/epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 to
// Gregorian date and time of day, covering 1970 through 2106-02-07 06:28:15.
// The converter is an 8-stage pipeline: it takes one transaction per clock
// while the output is not stalled. The divisions by 86400, 3600, 60 and by the
// 1461-day four-year cycle are reciprocal multiplies, each followed by a
// register, and those multipliers set the stage count. A stall on the output
// freezes the whole pipeline, so o_stall rises only while a finished result
// is held on the output.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_index,
    output logic [11:0] o_year_number,
    output logic [4:0]  o_hour_of_day,
    output logic [5:0]  o_minute_of_hour,
    output logic [5:0]  o_second_of_minute
);
    import epc_pkg::*;

    logic [PIPE_DEPTH-1:0] r_vld;
    t_pipe_ctl             w_ctl;
    logic [15:0]           w_days;
    logic [16:0]           w_rem;

    assign o_stall  = r_vld[PIPE_DEPTH-1] & i_stall;
    assign w_ctl.en = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ctl.en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    epc_split u_split (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_secs (i_epoch_seconds),
        .o_days (w_days),
        .o_rem  (w_rem)
    );

    epc_tod u_tod (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_rem    (w_rem),
        .o_hour   (o_hour_of_day),
        .o_minute (o_minute_of_hour),
        .o_second (o_second_of_minute)
    );

    epc_date u_date (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_days  (w_days),
        .o_day   (o_day_of_month),
        .o_month (o_month_index),
        .o_year  (o_year_number)
    );

    assign o_valid = r_vld[PIPE_DEPTH-1];

endmodule

[hw/rtl/epc_split.sv]
`timescale 1ns / 1ps

module epc_split (
    input  logic                 i_clk,
    input  epc_pkg::t_pipe_ctl   i_ctl,
    input  logic [31:0]          i_secs,
    output logic [15:0]          o_days,
    output logic [16:0]          o_rem
);
    import epc_pkg::*;

    logic [31:0] r_secs1;
    logic [50:0] r_prod1;
    logic [15:0] r_days2;
    logic [16:0] r_rem2;

    logic [15:0] n_days;
    logic [31:0] n_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_secs1 <= i_secs;
            r_prod1 <= 51'(i_secs[31:7]) * 51'(DAY_RECIP);
        end
    end

    always_comb begin
        n_days = r_prod1[DAY_SHIFT +: 16];
        n_diff = r_secs1 - (32'(n_days) * SECS_PER_DAY);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_days2 <= n_days;
            r_rem2  <= n_diff[16:0];
        end
    end

    assign o_days = r_days2;
    assign o_rem  = r_rem2;

endmodule

[hw/rtl/epc_tod.sv]
`timescale 1ns / 1ps

module epc_tod (
    input  logic                 i_clk,
    input  epc_pkg::t_pipe_ctl   i_ctl,
    input  logic [16:0]          i_rem,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [5:0]           o_second
);
    import epc_pkg::*;

    logic [26:0] r_hprod3;
    logic [16:0] r_rem3;
    logic [4:0]  r_hour4;
    logic [11:0] r_rem4;
    logic [20:0] r_mprod5;
    logic [4:0]  r_hour5;
    logic [11:0] r_rem5;
    logic [4:0]  r_hour6, r_hour7, r_hour8;
    logic [5:0]  r_min6, r_min7, r_min8;
    logic [5:0]  r_sec6, r_sec7, r_sec8;

    logic [4:0]  n_hour;
    logic [16:0] n_rem_h;
    logic [5:0]  n_min;
    logic [11:0] n_rem_m;

    always_comb begin
        n_hour  = r_hprod3[25:21];
        n_rem_h = r_rem3 - (17'(n_hour) * SECS_PER_HOUR);
        n_min   = r_mprod5[19:14];
        n_rem_m = r_rem5 - (12'(n_min) * SECS_PER_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_hprod3 <= 27'(i_rem[16:4]) * 27'(HOUR_RECIP);
            r_rem3   <= i_rem;
            r_hour4  <= n_hour;
            r_rem4   <= n_rem_h[11:0];
            r_mprod5 <= 21'(r_rem4[11:2]) * 21'(MIN_RECIP);
            r_hour5  <= r_hour4;
            r_rem5   <= r_rem4;
            r_hour6  <= r_hour5;
            r_min6   <= n_min;
            r_sec6   <= n_rem_m[5:0];
            // hold alignment with the date path
            r_hour7  <= r_hour6;
            r_min7   <= r_min6;
            r_sec7   <= r_sec6;
            r_hour8  <= r_hour7;
            r_min8   <= r_min7;
            r_sec8   <= r_sec7;
        end
    end

    assign o_hour   = r_hour8;
    assign o_minute = r_min8;
    assign o_second = r_sec8;

endmodule

[hw/rtl/epc_date.sv]
`timescale 1ns / 1ps

module epc_date (
    input  logic                 i_clk,
    input  epc_pkg::t_pipe_ctl   i_ctl,
    input  logic [15:0]          i_days,
    output logic [4:0]           o_day,
    output logic [3:0]           o_month,
    output logic [11:0]          o_year
);
    import epc_pkg::*;

    logic [15:0] r_dp3;
    logic [32:0] r_dprod4;
    logic [15:0] r_dp4;
    logic [5:0]  r_q5;
    logic [10:0] r_rc5;
    logic [11:0] r_year6, r_year7, r_year8;
    logic [8:0]  r_doy6, r_doy7;
    logic        r_leap6, r_leap7;
    logic [3:0]  r_month7, r_month8;
    logic [4:0]  r_day8;

    logic [15:0] n_d;
    logic [15:0] n_dp;
    logic [5:0]  n_q;
    logic [15:0] n_rc;
    logic [1:0]  n_yc;
    logic [10:0] n_ystart;
    logic [10:0] n_doy;
    logic [3:0]  n_month;
    logic [8:0]  n_day0;

    always_comb begin
        n_d  = i_days + DAYS_1968_1970;
        // skip the nonexistent 2100-02-29 so every cycle looks uniform
        n_dp = n_d + ((n_d >= DAY_2100_MAR1) ? 16'd1 : 16'd0);
        n_q  = r_dprod4[CYCLE_SHIFT +: 6];
        n_rc = r_dp4 - (16'(n_q) * DAYS_PER_CYCLE);

        priority if (r_rc5 >= CYC_Y3_START) begin
            n_yc     = 2'd3;
            n_ystart = CYC_Y3_START;
        end else if (r_rc5 >= CYC_Y2_START) begin
            n_yc     = 2'd2;
            n_ystart = CYC_Y2_START;
        end else if (r_rc5 >= CYC_Y1_START) begin
            n_yc     = 2'd1;
            n_ystart = CYC_Y1_START;
        end else begin
            n_yc     = 2'd0;
            n_ystart = 11'd0;
        end
        n_doy = r_rc5 - n_ystart;

        n_month = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_doy6 >= month_start(4'(m), r_leap6)) begin
                n_month = n_month + 4'd1;
            end
        end

        n_day0 = r_doy7 - month_start(r_month7, r_leap7);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_dp3    <= n_dp;
            r_dprod4 <= 33'(r_dp3) * 33'(CYCLE_RECIP);
            r_dp4    <= r_dp3;
            r_q5     <= n_q;
            r_rc5    <= n_rc[10:0];
            r_year6  <= CYCLE_BASE_YEAR + 12'({r_q5, 2'b00}) + 12'(n_yc);
            r_doy6   <= n_doy[8:0];
            r_leap6  <= (n_yc == 2'd0);
            r_month7 <= n_month;
            r_doy7   <= r_doy6;
            r_leap7  <= r_leap6;
            r_year7  <= r_year6;
            r_month8 <= r_month7;
            r_year8  <= r_year7;
            r_day8   <= n_day0[4:0] + 5'd1;
        end
    end

    assign o_day   = r_day8;
    assign o_month = r_month8;
    assign o_year  = r_year8;

endmodule

[hw/rtl/epc_checker.sv]
`timescale 1ns / 1ps

module epc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [4:0]  o_day_of_month,
    input  logic [3:0]  o_month_index,
    input  logic [11:0] o_year_number,
    input  logic [4:0]  o_hour_of_day,
    input  logic [5:0]  o_minute_of_hour,
    input  logic [5:0]  o_second_of_minute
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_year_number) && $stable(o_day_of_month)
            && $stable(o_second_of_minute))
        else $error("stalled output payload changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hour_of_day < 5'd24 && o_minute_of_hour < 6'd60
            && o_second_of_minute < 6'd60)
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_month_index < 4'd12 && o_day_of_month != 5'd0
            && o_year_number >= 12'd1970 && o_year_number <= 12'd2106)
        else $error("calendar date out of range");

endmodule

bind epoch_seconds_to_calendar epc_checker u_epc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_day_of_month     (o_day_of_month),
    .o_month_index      (o_month_index),
    .o_year_number      (o_year_number),
    .o_hour_of_day      (o_hour_of_day),
    .o_minute_of_hour   (o_minute_of_hour),
    .o_second_of_minute (o_second_of_minute)
);
